>>> hw/rtl/assert_macros.svh
// Assertion helper macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked at every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/prbm_pkg.sv
// ----------------------------------------------------------------------------
// prbm_pkg
// Shared types, constants and codes of the path rule block matcher.
// ----------------------------------------------------------------------------
`default_nettype none
package prbm_pkg;
    // Table geometry is tied to the field widths of the stream interface.
    localparam int RULE_SLOTS      = 32;
    localparam int PATTERN_MAX     = 63;
    localparam int PATH_CAP_DEF    = 256;

    localparam logic [1:0] FUNC_HEADER  = 2'd0;
    localparam logic [1:0] FUNC_PATTERN = 2'd1;
    localparam logic [1:0] FUNC_PATH    = 2'd2;

    localparam logic [7:0] OP_SUFFIX = 8'd1;
    localparam logic [7:0] OP_PREFIX = 8'd2;
    localparam logic [7:0] OP_EQUALS = 8'd3;

    localparam logic CFG_ENFORCE = 1'b0;
    localparam logic CFG_COUNT   = 1'b1;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_CMP,
        ST_NEXT,
        ST_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic take_in;
        logic scan_start;
        logic rule_load;
        logic cmp_step;
        logic rule_next;
        logic result_load;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_go;
        logic rule_more;
        logic rule_skip;
        logic cmp_done;
        logic cmp_fail;
    } t_status;
endpackage
`default_nettype wire

>>> hw/rtl/path_rule_block_matcher.sv
// ----------------------------------------------------------------------------
// path_rule_block_matcher
// Streams rule writes and path bytes, scans rules on the last path byte.
// ----------------------------------------------------------------------------
// Channel  | Dir | Contents
// s_axis   | in  | tdata: func, rule_index, rule_active, rule_event, rule_op,
//          |     |        pattern_len, pattern_pos, data_byte; tlast: path_last;
//          |     |        tuser: path_event
// m_axis   | out | tdata: blocked, match_rule, path_length
// cfg      | in  | index 0 enforce_on, index 1 active_rule_count
//
// Header, pattern and non-last path beats are taken while no scan runs.
// A last path beat starts a scan: each rule header is loaded and checked,
// a rule that fails the check is skipped, a rule that passes has its pattern
// compared byte by byte with the path, and the result is then loaded; the
// single read port of the pattern memory sets the byte rate. Input is stalled
// during the scan and while a result waits in the output register. Reset is
// synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module path_rule_block_matcher import prbm_pkg::*; #(
    parameter int PATH_CAP    = PATH_CAP_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // func[1:0], rule_index[6:2], rule_active[7], rule_event[15:8],
    // rule_op[23:16], pattern_len[31:24], pattern_pos[37:32], data_byte[45:38]
    input  wire [IN_DATA_W-1:0]   s_axis_tdata,
    input  wire                   s_axis_tlast,
    // path_event[7:0]
    input  wire [7:0]             s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // blocked[0], match_rule[5:1], path_length[13:6]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_index,
    input  wire [5:0]             i_cfg_data
);
    t_cmd       w_cmd;
    t_status    w_status;
    logic       w_blocked;
    logic [4:0] w_match;
    logic [7:0] w_plen;
    logic       r_ovalid;
    logic       w_scan;
    logic       s_axis_tready_c;

    assign w_scan = s_axis_tdata[1:0] == FUNC_PATH && s_axis_tlast;

    prbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid && !r_ovalid),
        .i_in_scan  (w_scan),
        .i_out_busy (r_ovalid && !m_axis_tready),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready_c),
        .o_cmd      (w_cmd)
    );

    assign s_axis_tready = s_axis_tready_c && !r_ovalid;

    prbm_datapath #(
        .PATH_CAP    (PATH_CAP)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_func        (s_axis_tdata[1:0]),
        .i_rule_index  (s_axis_tdata[6:2]),
        .i_rule_active (s_axis_tdata[7]),
        .i_rule_event  (s_axis_tdata[15:8]),
        .i_rule_op     (s_axis_tdata[23:16]),
        .i_pattern_len (s_axis_tdata[31:24]),
        .i_pattern_pos (s_axis_tdata[37:32]),
        .i_data_byte   (s_axis_tdata[45:38]),
        .i_path_event  (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_status      (w_status),
        .o_blocked     (w_blocked),
        .o_match_rule  (w_match),
        .o_path_length (w_plen)
    );

    // The result register is loaded as the scan finishes and held until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.result_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, w_plen, w_match, w_blocked};
endmodule
`default_nettype wire

>>> hw/rtl/prbm_ctrl.sv
// ----------------------------------------------------------------------------
// prbm_ctrl
// Controller of the matcher: item intake, rule scan sequencing and result.
// ----------------------------------------------------------------------------
`default_nettype none
module prbm_ctrl import prbm_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    input  wire     i_in_scan,
    input  wire     i_out_busy,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_scan) begin
                    n_state = ST_HDR;
                end
            end
            ST_HDR: begin
                if (!i_status.scan_go || !i_status.rule_more) begin
                    n_state = ST_DONE;
                end else if (i_status.rule_skip) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_status.cmp_fail) begin
                    n_state = ST_NEXT;
                end else if (i_status.cmp_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_NEXT: n_state = ST_HDR;
            ST_DONE: begin
                if (!i_out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.take_in    = i_in_valid;
                o_cmd.scan_start = i_in_valid && i_in_scan;
            end
            ST_HDR:  o_cmd.rule_load = 1'b1;
            ST_CMP:  o_cmd.cmp_step  = 1'b1;
            ST_NEXT: o_cmd.rule_next = 1'b1;
            ST_DONE: o_cmd.result_load = !i_out_busy;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> hw/rtl/prbm_datapath.sv
// ----------------------------------------------------------------------------
// prbm_datapath
// Rule table, pattern and path memories, byte comparator and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module prbm_datapath import prbm_pkg::*; #(
    parameter int PATH_CAP    = PATH_CAP_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cmd       i_cmd,
    input  wire [1:0]  i_func,
    input  wire [4:0]  i_rule_index,
    input  wire        i_rule_active,
    input  wire [7:0]  i_rule_event,
    input  wire [7:0]  i_rule_op,
    input  wire [7:0]  i_pattern_len,
    input  wire [5:0]  i_pattern_pos,
    input  wire [7:0]  i_data_byte,
    input  wire [7:0]  i_path_event,
    input  wire        i_cfg_we,
    input  wire        i_cfg_index,
    input  wire [5:0]  i_cfg_data,
    output t_status    o_status,
    output logic       o_blocked,
    output logic [4:0] o_match_rule,
    output logic [7:0] o_path_length
);
    localparam int SW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CW = $clog2(RULE_SLOTS + 1);
    localparam int AW = $clog2(PATH_CAP);
    localparam int LW = AW + 1;
    localparam int MW = $clog2(RULE_SLOTS * PATTERN_MAX);
    localparam int MD = RULE_SLOTS * PATTERN_MAX;

    // Rule headers in flip-flops, reset to inactive.
    logic             r_act [RULE_SLOTS];
    logic [7:0]       r_evt [RULE_SLOTS];
    logic [7:0]       r_op  [RULE_SLOTS];
    logic [7:0]       r_len [RULE_SLOTS];
    logic [7:0]       r_pat_mem  [MD];
    logic [7:0]       r_path_mem [PATH_CAP];
    logic [LW-1:0]    r_cnt;
    logic             r_enf;
    logic [5:0]       r_rcnt;
    logic [7:0]       r_ev;
    logic [LW-1:0]    r_blen;
    logic [SW:0]      r_slot;
    logic [7:0]       r_plen;
    logic [7:0]       r_k;
    logic [LW-1:0]    r_off;
    logic [MW-1:0]    r_pbase;
    logic [7:0]       r_pat_q, r_path_q;
    logic             r_qv;
    logic             r_hit_final;
    logic             r_blocked;
    logic [4:0]       r_match;
    logic [7:0]       r_plength;

    logic [CW-1:0] w_lim;
    logic [SW-1:0] w_s;
    logic          w_bad;
    logic [MW-1:0] w_pidx;
    logic [LW-1:0] w_bidx;
    logic [5:0]    w_cap;

    assign w_cap = (r_rcnt > 6'(RULE_SLOTS)) ? 6'(RULE_SLOTS) : r_rcnt;
    assign w_lim = CW'(w_cap);
    assign w_s   = r_slot[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enf  <= 1'b0;
            r_rcnt <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ENFORCE) begin
                r_enf <= i_cfg_data[0];
            end else begin
                r_rcnt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RULE_SLOTS; i++) begin
                r_act[i] <= 1'b0;
                r_evt[i] <= '0;
                r_op[i]  <= '0;
                r_len[i] <= '0;
            end
        end else if (i_cmd.take_in && i_func == FUNC_HEADER
                     && 32'(i_rule_index) < RULE_SLOTS) begin
            r_act[i_rule_index[SW-1:0]] <= i_rule_active;
            r_evt[i_rule_index[SW-1:0]] <= i_rule_event;
            r_op[i_rule_index[SW-1:0]]  <= i_rule_op;
            r_len[i_rule_index[SW-1:0]] <= i_pattern_len;
        end
    end

    // Pattern memory: one write port from items, one registered read port.
    assign w_pidx = MW'(r_pbase + MW'(r_k));
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in && i_func == FUNC_PATTERN && 32'(i_rule_index) < RULE_SLOTS
            && 32'(i_pattern_pos) < PATTERN_MAX) begin
            r_pat_mem[MW'(i_rule_index[SW-1:0] * PATTERN_MAX) + MW'(i_pattern_pos)]
                <= i_data_byte;
        end
        r_pat_q <= r_pat_mem[w_pidx];
    end

    // Path memory.
    assign w_bidx = LW'(r_off + LW'(r_k));
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in && i_func == FUNC_PATH && r_cnt < LW'(PATH_CAP - 1)) begin
            r_path_mem[r_cnt[AW-1:0]] <= i_data_byte;
        end
        r_path_q <= r_path_mem[w_bidx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.scan_start) begin
            r_cnt <= '0;
        end else if (i_cmd.take_in && i_func == FUNC_PATH && r_cnt < LW'(PATH_CAP - 1)) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Rule check from the header: an inactive rule or a bad length, op or event skips the rule.
    always_comb begin
        w_bad = !r_act[w_s] || r_evt[w_s] != r_ev || r_len[w_s] == 8'd0
              || 32'(r_len[w_s]) > PATTERN_MAX || 32'(r_len[w_s]) > 32'(r_blen);
        case (r_op[w_s])
            OP_SUFFIX, OP_PREFIX: ;
            OP_EQUALS: w_bad = w_bad || 32'(r_len[w_s]) != 32'(r_blen);
            default:   w_bad = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_ev   <= i_path_event;
            r_blen <= (r_cnt < LW'(PATH_CAP - 1)) ? r_cnt + 1'b1 : r_cnt;
            r_slot <= '0;
            r_pbase <= '0;
        end
        if (i_cmd.rule_load) begin
            r_plen <= r_len[w_s];
            r_k    <= '0;
            r_qv   <= 1'b0;
            r_off  <= (r_op[w_s] == OP_SUFFIX) ? LW'(r_blen - LW'(r_len[w_s])) : '0;
        end
        if (i_cmd.cmp_step) begin
            r_qv <= 1'b1;
            if (r_k != r_plen) begin
                r_k <= r_k + 1'b1;
            end
        end
        if (i_cmd.rule_next) begin
            r_slot  <= r_slot + 1'b1;
            r_pbase <= MW'(r_pbase + MW'(PATTERN_MAX));
        end
    end

    // Comparison runs one byte behind the address because reads are registered.
    always_comb begin
        o_status.scan_go   = r_enf && r_blen != '0;
        o_status.rule_more = 32'(r_slot) < 32'(w_lim);
        o_status.rule_skip = w_bad;
        o_status.cmp_fail  = r_qv && r_k != 8'd0 && r_pat_q != r_path_q;
        o_status.cmp_done  = r_qv && r_k == r_plen && !o_status.cmp_fail;
    end

    // The hit flag is set when the final pattern byte compares equal; any
    // earlier mismatch has already moved the scan to the next rule.
    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_blocked <= r_hit_final;
            r_match   <= r_hit_final ? 5'(r_slot) : 5'd0;
            r_plength <= (r_blen > LW'(255)) ? 8'd255 : 8'(r_blen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_hit_final <= 1'b0;
        end else if (i_cmd.cmp_step && r_qv && r_k == r_plen && r_pat_q == r_path_q) begin
            r_hit_final <= 1'b1;
        end
    end

    assign o_blocked     = r_blocked;
    assign o_match_rule  = r_match;
    assign o_path_length = r_plength;
endmodule
`default_nettype wire

>>> hw/rtl/prbm_checker.sv
// ----------------------------------------------------------------------------
// prbm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module prbm_checker import prbm_pkg::*; (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  s_axis_tvalid,
    input wire                  s_axis_tready,
    input wire [IN_DATA_W-1:0]  s_axis_tdata,
    input wire                  s_axis_tlast,
    input wire                  m_axis_tvalid,
    input wire                  m_axis_tready,
    input wire [OUT_DATA_W-1:0] m_axis_tdata
);
    // A pending result blocks new input.
    `ASSERT_IMPL(a_no_in_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    // A result that is not blocked never names a rule.
    `ASSERT_IMPL(a_match_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0],
        m_axis_tdata[5:1] == 5'd0)
    // A last path beat stops intake on the next cycle.
    `ASSERT_NEXT(a_scan_stalls, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tlast && s_axis_tdata[1:0] == FUNC_PATH,
        !s_axis_tready)
    // Path length is never zero on a result.
    `ASSERT_IMPL(a_len_nonzero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[13:6] != 8'd0)
endmodule

bind path_rule_block_matcher prbm_checker u_prbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> sim/tb_path_rule_block_matcher.sv
// ----------------------------------------------------------------------------
// Testbench for path_rule_block_matcher
// Writes rule headers and patterns, streams paths and checks every scan
// result against a behavioral predictor kept inside this module.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_path_rule_block_matcher;
    import prbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS  = 32;
    localparam int PATMAX = 63;
    localparam int CAP    = 256;

    // Packed from the highest bit down as on m_axis_tdata.
    typedef struct packed {
        logic [7:0] path_length;
        logic [4:0] match_rule;
        logic       blocked;
    } t_verdict;

    typedef struct {
        logic       active;
        logic [7:0] ev;
        logic [7:0] op;
        logic [7:0] len;
    } t_rule;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // func, rule_index, rule_active, rule_event, rule_op, pattern_len,
    // pattern_pos, data_byte from the lowest bit up
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    // path_event
    logic [7:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // blocked, match_rule, path_length from the lowest bit up
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we;
    logic                  i_cfg_index;
    logic [5:0]            i_cfg_data;

    path_rule_block_matcher u_dut (.*);

    // Predictor state: a mirror of the block's rule table and path buffer.
    t_rule      rules [SLOTS];
    logic [7:0] patterns [SLOTS][PATMAX];
    logic [7:0] path_bytes [CAP];
    int         path_fill;
    logic       enforce;
    logic [5:0] scan_count;

    t_verdict   pending_verdicts [$];
    int         error_count;
    int         verdicts_seen;
    int         beats_sent;
    bit         calm;     // when set, neither side idles

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Checks whether one rule's pattern fits the current path.
    function automatic bit rule_fits(input int slot, input int plen_path);
        int plen;
        int off;
        plen = rules[slot].len;
        if (plen == 0 || plen > PATMAX || plen > plen_path) return 0;
        case (rules[slot].op)
            OP_SUFFIX: off = plen_path - plen;
            OP_PREFIX: off = 0;
            OP_EQUALS: begin
                if (plen_path != plen) return 0;
                off = 0;
            end
            default: return 0;
        endcase
        for (int i = 0; i < plen; i++)
            if (path_bytes[off + i] != patterns[slot][i]) return 0;
        return 1;
    endfunction

    // Updates the mirror for one accepted beat and queues any verdict.
    function automatic void predict_verdict(input logic [IN_DATA_W-1:0] d,
                                            input logic last, input logic [7:0] ev);
        logic [1:0] fn;
        int         slot;
        int         pos;
        int         cnt;
        t_verdict   v;
        fn   = d[1:0];
        slot = d[6:2];
        pos  = d[37:32];
        if (fn == FUNC_HEADER) begin
            rules[slot].active = d[7];
            rules[slot].ev     = d[15:8];
            rules[slot].op     = d[23:16];
            rules[slot].len    = d[31:24];
        end else if (fn == FUNC_PATTERN) begin
            if (pos < PATMAX) begin
                patterns[slot][pos] = d[45:38];
            end
        end else if (fn == FUNC_PATH) begin
            if (path_fill < CAP - 1) begin
                path_bytes[path_fill] = d[45:38];
                path_fill++;
            end
            if (last) begin
                v = '0;
                cnt = scan_count > SLOTS ? SLOTS : scan_count;
                if (enforce) begin
                    for (int i = 0; i < cnt; i++) begin
                        if (rules[i].active && rules[i].ev == ev && rule_fits(i, path_fill)) begin
                            v.blocked    = 1'b1;
                            v.match_rule = i[4:0];
                            break;
                        end
                    end
                end
                v.path_length = path_fill > 255 ? 8'd255 : path_fill[7:0];
                pending_verdicts.push_back(v);
                path_fill = 0;
            end
        end
    endfunction

    // Sends one beat, with an optional idle burst before it.
    task automatic send_beat(input int fn, input int slot, input int act,
                             input int ev, input int op,
                             input int plen, input int pos,
                             input int data, input int last,
                             input int pev);
        logic [IN_DATA_W-1:0] d;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        d = '0;
        d[1:0] = fn[1:0]; d[6:2] = slot[4:0]; d[7] = act[0]; d[15:8] = ev[7:0];
        d[23:16] = op[7:0]; d[31:24] = plen[7:0]; d[37:32] = pos[5:0];
        d[45:38] = data[7:0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last[0];
        s_axis_tuser  <= pev[7:0];
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_verdict(d, last[0], pev[7:0]);
        beats_sent++;
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    // Writes a register; only called while the block is idle.
    task automatic write_reg(input int idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx[0];
        i_cfg_data  <= val[5:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx[0] == CFG_ENFORCE) enforce = val[0];
        else scan_count = val[5:0];
    endtask

    // Waits for all verdicts, plus margin for a scan that yields nothing.
    task automatic drain();
        int guard;
        guard = 0;
        end_burst();
        while (pending_verdicts.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_rule(input int slot, input int act, input int ev,
                              input int op, input int len,
                              input logic [7:0] pat []);
        send_beat(FUNC_HEADER, slot, act, ev, op, len, $urandom, $urandom, $urandom, $urandom);
        foreach (pat[i])
            send_beat(FUNC_PATTERN, slot, $urandom, $urandom, $urandom, $urandom,
                      i, pat[i], $urandom, $urandom);
    endtask

    task automatic send_path(input logic [7:0] p [], input int ev);
        foreach (p[i])
            send_beat(FUNC_PATH, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, p[i], i == p.size() - 1, ev);
    endtask

    // Random pattern, which is always fully written so no unwritten byte is read.
    function automatic void rand_bytes(ref logic [7:0] b [], input int n, input int alpha);
        b = new[n];
        foreach (b[i]) b[i] = alpha ? 8'(8'h61 + $urandom_range(0, 2)) : 8'($urandom);
    endfunction

    // Every slot gets a fully written pattern so any scan reads defined bytes.
    task automatic test_directed();
        logic [7:0] pat [];
        logic [7:0] p [];
        write_reg(CFG_ENFORCE, 1);
        write_reg(CFG_COUNT, 32);
        for (int s = 0; s < SLOTS; s++) begin
            rand_bytes(pat, s == 0 ? PATMAX : 3, 1);
            write_rule(s, s != 4, 1 + s % 4, 1 + s % 3, pat.size(), pat);
        end
        // Out-of-range pattern position and unknown func are ignored.
        send_beat(FUNC_PATTERN, 3, 1, 0, 0, 0, 63, 8'hFF, 0, 0);
        send_beat(3, 31, 1, 8'hFF, 8'hFF, 8'hFF, 6'h3F, 8'hFF, 1, 8'hFF);
        // Bad header: zero length, unknown op, length above the maximum.
        write_rule(5, 1, 1, 8'hFF, 0, pat);
        write_rule(6, 1, 2, OP_PREFIX, 255, pat);
        write_rule(7, 1, 3, OP_EQUALS, 0, pat);
        // Equals on rule 2, prefix on 1, suffix on 0 with a full-length pattern.
        p = new[3]; foreach (p[i]) p[i] = patterns[2][i];
        send_path(p, 3);
        p = new[10]; foreach (p[i]) p[i] = i < 3 ? patterns[1][i] : 8'h00;
        send_path(p, 2);
        p = new[PATMAX + 2]; foreach (p[i]) p[i] = i < 2 ? 8'hFF : patterns[0][i - 2];
        send_path(p, 1);
        // Single-byte path and a path that overruns the buffer.
        p = new[1]; p[0] = 8'h00; send_path(p, 8'hFF);
        rand_bytes(p, 300, 1); send_path(p, 4);
        drain();
        write_reg(CFG_ENFORCE, 0);
        p = new[3]; foreach (p[i]) p[i] = patterns[2][i];
        send_path(p, 3);
        drain();
        write_reg(CFG_ENFORCE, 1);
        write_reg(CFG_COUNT, 63);
        send_path(p, 3);
        drain();
        write_reg(CFG_COUNT, 0);
        send_path(p, 3);
        drain();
    endtask

    // Random rule rewrites and paths mostly built from stored patterns.
    task automatic test_random(input int target);
        logic [7:0] pat [];
        logic [7:0] p [];
        int s;
        int n;
        while (beats_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    s = $urandom_range(0, SLOTS - 1);
                    n = $urandom_range(0, 15) == 0 ? 8 : $urandom_range(1, 6);
                    rand_bytes(pat, n, 1);
                    // A bad length stays above the maximum so no unwritten byte is read.
                    write_rule(s, $urandom_range(0, 5) != 0, $urandom_range(0, 5),
                               $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 3),
                               $urandom_range(0, 19) == 0 ? $urandom_range(64, 255) : n,
                               pat);
                end
                2: send_beat($urandom_range(1, 3), $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, 0, $urandom);
                default: begin
                    s = $urandom_range(0, SLOTS - 1);
                    n = $urandom_range(0, 3);
                    rand_bytes(p, $urandom_range(1, 5), 1);
                    // Mostly wrap a stored pattern in a random prefix, suffix, both or neither.
                    if ($urandom_range(0, 3) != 0) begin
                        pat = new[rules[s].len > 0 && rules[s].len <= PATMAX ? rules[s].len : 0];
                        foreach (pat[i]) pat[i] = patterns[s][i];
                        case (n)
                            0: p = pat;
                            1: p = {pat, p};
                            2: p = {p, pat};
                            default: p = {p, pat, p};
                        endcase
                        if (p.size() == 0) p = new[1];
                    end
                    send_path(p, $urandom_range(0, 5));
                end
            endcase
        end
        drain();
    endtask

    task automatic test_settings();
        write_reg(CFG_COUNT, 1);
        test_random(beats_sent + 150);
        write_reg(CFG_COUNT, 20);
        test_random(beats_sent + 150);
        write_reg(CFG_ENFORCE, 0);
        write_reg(CFG_COUNT, 32);
        test_random(beats_sent + 100);
        write_reg(CFG_ENFORCE, 1);
    endtask

    // Result checker and random backpressure on the output side.
    always @(posedge i_clk) begin
        t_verdict got;
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[13:0];
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_verdicts.pop_front();
                if (got.blocked !== want.blocked)
                    report_mismatch($sformatf("blocked %b want %b", got.blocked, want.blocked));
                if (got.match_rule !== want.match_rule)
                    report_mismatch($sformatf("match_rule %0d want %0d",
                                              got.match_rule, want.match_rule));
                if (got.path_length !== want.path_length)
                    report_mismatch($sformatf("path_length %0d want %0d",
                                              got.path_length, want.path_length));
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= stall_left == 1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(1, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0; s_axis_tuser = '0;
        i_cfg_we = 1'b0; i_cfg_index = 1'b0; i_cfg_data = '0;
        error_count = 0; verdicts_seen = 0; beats_sent = 0; calm = 0;
        path_fill = 0; enforce = 0; scan_count = 0;
        foreach (rules[i]) rules[i] = '{1'b0, 8'd0, 8'd0, 8'd0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(1400);
        test_settings();
        calm = 1;
        test_random(beats_sent + 50);
        drain();

        $display("Sent %0d beats and checked %0d scan results over rule table rewrites,",
                 beats_sent, verdicts_seen);
        $display("enforcement on and off, and scan counts of 0, 1, 20, 32 and 63.");
        if (error_count == 0 && pending_verdicts.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            if (pending_verdicts.size() != 0)
                $display("%0d expected results never arrived", pending_verdicts.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
`default_nettype wire
